FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion macros for the ordered key/value table.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define OKVT_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define OKVT_ASSERT(label, prop, msg) \
    `OKVT_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

FILE: rtl/okvt_pkg.sv
// ----------------------------------------------------------------------------
// okvt_pkg
// Types and constants shared by the ordered key/value table modules.
// ----------------------------------------------------------------------------
package okvt_pkg;

    localparam int CAPACITY = 16;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 5;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam count_t CAP_COUNT = count_t'(CAPACITY);

    typedef enum logic [2:0] {
        OP_SET       = 3'd0,
        OP_GET       = 3'd1,
        OP_KEY_AT    = 3'd2,
        OP_VALUE_AT  = 3'd3,
        OP_DELETE    = 3'd4,
        OP_CLEAR     = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } ctrl_state_t;

    // A request travelling down the row of cells, one cell per cycle.
    typedef struct packed {
        logic    valid;
        opcode_t op;
        word_t   key;
        word_t   value;
        count_t  remaining;     // occupied cells still ahead, this one included
        count_t  pos_left;      // 1 at the cell addressed by an index request
        logic    allow_append;
        logic    found;
        logic    appended;
        word_t   data;
    } probe_t;

endpackage

FILE: rtl/okvt_cell.sv
// ----------------------------------------------------------------------------
// okvt_cell
// One table slot: holds a key and a value and acts on the passing request.
// ----------------------------------------------------------------------------
module okvt_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  okvt_pkg::probe_t  probe_in,
    output okvt_pkg::probe_t  probe_out,
    input  okvt_pkg::word_t   next_key,
    input  okvt_pkg::word_t   next_value,
    output okvt_pkg::word_t   cell_key,
    output okvt_pkg::word_t   cell_value
);

    okvt_pkg::probe_t probe_reg;
    okvt_pkg::word_t  key_reg;
    okvt_pkg::word_t  key_next;
    okvt_pkg::word_t  value_reg;
    okvt_pkg::word_t  value_next;
    logic             in_use;
    logic             key_hit;

    assign cell_key   = key_reg;
    assign cell_value = value_reg;
    assign in_use     = (probe_reg.remaining != '0);
    assign key_hit    = in_use && !probe_reg.found && (key_reg == probe_reg.key);

    always_comb begin
        probe_out  = probe_reg;
        key_next   = key_reg;
        value_next = value_reg;
        if (probe_reg.valid) begin
            case (probe_reg.op)
                okvt_pkg::OP_SET: begin
                    if (key_hit) begin
                        value_next      = probe_reg.value;
                        probe_out.found = 1'b1;
                    end else if (!in_use && !probe_reg.found && probe_reg.allow_append) begin
                        // First free slot: append here.
                        key_next           = probe_reg.key;
                        value_next         = probe_reg.value;
                        probe_out.found    = 1'b1;
                        probe_out.appended = 1'b1;
                    end
                end
                okvt_pkg::OP_GET: begin
                    if (key_hit) begin
                        probe_out.found = 1'b1;
                        probe_out.data  = value_reg;
                    end
                end
                okvt_pkg::OP_KEY_AT, okvt_pkg::OP_VALUE_AT: begin
                    if (in_use && probe_reg.pos_left == okvt_pkg::count_t'(1)) begin
                        probe_out.found = 1'b1;
                        probe_out.data  = (probe_reg.op == okvt_pkg::OP_KEY_AT) ?
                                          key_reg : value_reg;
                    end
                end
                okvt_pkg::OP_DELETE: begin
                    if (key_hit) begin
                        probe_out.found = 1'b1;
                        probe_out.data  = value_reg;
                    end
                    // From the deleted slot on, every slot takes its successor.
                    // The successor has not seen the request yet, so it still
                    // holds its old contents.
                    if (key_hit || probe_reg.found) begin
                        key_next   = next_key;
                        value_next = next_value;
                    end
                end
                default: begin
                end
            endcase
            if (in_use) begin
                probe_out.remaining = probe_reg.remaining - okvt_pkg::count_t'(1);
            end
            if (probe_reg.pos_left != '0) begin
                probe_out.pos_left = probe_reg.pos_left - okvt_pkg::count_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg <= '0;
        end else begin
            probe_reg <= probe_in;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule

FILE: rtl/okvt_ctrl.sv
// ----------------------------------------------------------------------------
// okvt_ctrl
// Request sequencer: launches requests into the cell row, keeps the entry
// count and the limit register, and holds the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module okvt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_opcode,
    input  okvt_pkg::word_t   s_key,
    input  okvt_pkg::word_t   s_entry_value,
    input  okvt_pkg::count_t  s_position,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_ok,
    output okvt_pkg::word_t   m_data,
    output okvt_pkg::count_t  m_count,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  okvt_pkg::count_t  cfg_data,
    output okvt_pkg::probe_t  chain_in,
    input  okvt_pkg::probe_t  chain_out
);

    okvt_pkg::ctrl_state_t state_reg;
    okvt_pkg::ctrl_state_t state_next;
    okvt_pkg::count_t      count_reg;
    okvt_pkg::count_t      count_next;
    okvt_pkg::count_t      limit_reg;
    okvt_pkg::count_t      eff_limit;
    logic                  m_valid_reg;
    logic                  m_ok_reg;
    okvt_pkg::word_t       m_data_reg;
    okvt_pkg::count_t      m_count_reg;
    logic                  pend_ok_reg;
    logic                  pend_ok_next;
    okvt_pkg::word_t       pend_data_reg;
    okvt_pkg::word_t       pend_data_next;
    okvt_pkg::count_t      pend_count_reg;
    okvt_pkg::count_t      pend_count_next;
    okvt_pkg::opcode_t     req_op;
    logic                  accept;
    logic                  walk_op;
    logic                  load_out;

    assign req_op    = okvt_pkg::opcode_t'(s_opcode);
    assign eff_limit = (limit_reg > okvt_pkg::CAP_COUNT) ? okvt_pkg::CAP_COUNT : limit_reg;
    assign walk_op   = (req_op == okvt_pkg::OP_SET)      || (req_op == okvt_pkg::OP_GET)
                    || (req_op == okvt_pkg::OP_KEY_AT)   || (req_op == okvt_pkg::OP_VALUE_AT)
                    || (req_op == okvt_pkg::OP_DELETE);

    // Output decode.
    always_comb begin
        s_ready   = (state_reg == okvt_pkg::ST_IDLE);
        accept    = s_valid && s_ready;
        load_out  = (state_reg == okvt_pkg::ST_FINISH) && (!m_valid_reg || m_ready);
        cfg_ready = 1'b1;

        chain_in              = '0;
        chain_in.valid        = accept && walk_op;
        chain_in.op           = req_op;
        chain_in.key          = s_key;
        chain_in.value        = s_entry_value;
        chain_in.remaining    = count_reg;
        chain_in.pos_left     = s_position;
        chain_in.allow_append = (count_reg < eff_limit);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            okvt_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = walk_op ? okvt_pkg::ST_WALK : okvt_pkg::ST_FINISH;
                end
            end
            okvt_pkg::ST_WALK: begin
                if (chain_out.valid) begin
                    state_next = okvt_pkg::ST_FINISH;
                end
            end
            okvt_pkg::ST_FINISH: begin
                if (load_out) begin
                    state_next = okvt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = okvt_pkg::ST_IDLE;
            end
        endcase
    end

    // Pending result and count.
    always_comb begin
        pend_ok_next    = pend_ok_reg;
        pend_data_next  = pend_data_reg;
        pend_count_next = pend_count_reg;
        count_next      = count_reg;
        if (accept && !walk_op) begin
            if (req_op == okvt_pkg::OP_CLEAR) begin
                pend_ok_next    = 1'b1;
                pend_count_next = '0;
            end else begin
                pend_ok_next    = 1'b0;
                pend_count_next = count_reg;
            end
            pend_data_next = '0;
        end else if (state_reg == okvt_pkg::ST_WALK && chain_out.valid) begin
            pend_ok_next   = chain_out.found;
            pend_data_next = chain_out.data;
            if (chain_out.appended) begin
                pend_count_next = count_reg + okvt_pkg::count_t'(1);
            end else if (chain_out.op == okvt_pkg::OP_DELETE && chain_out.found) begin
                pend_count_next = count_reg - okvt_pkg::count_t'(1);
            end else begin
                pend_count_next = count_reg;
            end
        end
        if (load_out) begin
            count_next = pend_count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= okvt_pkg::ST_IDLE;
            count_reg   <= '0;
            limit_reg   <= okvt_pkg::CAP_COUNT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_ok_reg    <= pend_ok_next;
        pend_data_reg  <= pend_data_next;
        pend_count_reg <= pend_count_next;
        if (load_out) begin
            m_ok_reg    <= pend_ok_reg;
            m_data_reg  <= pend_data_reg;
            m_count_reg <= pend_count_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_ok    = m_ok_reg;
    assign m_data  = m_data_reg;
    assign m_count = m_count_reg;

    `OKVT_ASSERT(a_count_bounded, count_reg <= okvt_pkg::CAP_COUNT, "entry count above capacity")
    `OKVT_ASSERT(a_chain_out_in_walk, chain_out.valid |-> state_reg == okvt_pkg::ST_WALK, "request left the cell row outside a walk")
    `OKVT_ASSERT(a_count_moves_on_load, !$stable(count_reg) |-> $past(load_out), "entry count changed without a result")

endmodule

FILE: rtl/ordered_key_value_table.sv
// ----------------------------------------------------------------------------
// ordered_key_value_table
// Insertion-ordered table of 32-bit keys and 32-bit values built as a row
// of slot cells that a request walks through one cell per cycle.
// ----------------------------------------------------------------------------
// Each request (set, get, key at index, value at index, delete) enters the
// first cell of a row of CAPACITY slot cells (16 at the default capacity)
// and moves one cell per clock, so the walk over the row sets the cost: a
// walking request leaves the last cell into the pending result register,
// which moves into the output register once m_valid is low or m_ready is
// high. Clear and unused opcodes skip the walk and go straight to the
// pending result register. One request is in flight at a time; s_ready
// rises again once the result has moved into the output register, so the
// next request can start while that result still waits for m_ready. Set
// overwrites a matching key in place or appends at the first free slot
// while the limit allows it; delete returns the value and every later slot
// takes its successor's contents as the request passes, which closes the
// gap in the same walk. The capacity limit is written on the cfg port and
// should only change while no request is pending.
module ordered_key_value_table (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_opcode,
    input  logic [31:0]       s_key,
    input  logic [31:0]       s_entry_value,
    input  logic [4:0]        s_position,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_ok,
    output logic [31:0]       m_data,
    output logic [4:0]        m_count,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [4:0]        cfg_data
);

    // Request path through the row: chain[i] feeds cell i.
    okvt_pkg::probe_t chain [0:okvt_pkg::CAPACITY];
    okvt_pkg::word_t  slot_key   [0:okvt_pkg::CAPACITY-1];
    okvt_pkg::word_t  slot_value [0:okvt_pkg::CAPACITY-1];

    okvt_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_key         (s_key),
        .s_entry_value (s_entry_value),
        .s_position    (s_position),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ok          (m_ok),
        .m_data        (m_data),
        .m_count       (m_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .chain_in      (chain[0]),
        .chain_out     (chain[okvt_pkg::CAPACITY])
    );

    // The last slot has no successor; on a delete it takes zeros, which
    // fall outside the table once the count drops.
    for (genvar i = 0; i < okvt_pkg::CAPACITY; i++) begin : g_cell
        if (i == okvt_pkg::CAPACITY - 1) begin : g_last
            okvt_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .probe_in   (chain[i]),
                .probe_out  (chain[i+1]),
                .next_key   ('0),
                .next_value ('0),
                .cell_key   (slot_key[i]),
                .cell_value (slot_value[i])
            );
        end else begin : g_mid
            okvt_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .probe_in   (chain[i]),
                .probe_out  (chain[i+1]),
                .next_key   (slot_key[i+1]),
                .next_value (slot_value[i+1]),
                .cell_key   (slot_key[i]),
                .cell_value (slot_value[i])
            );
        end
    end

endmodule
